FILE: design/hew_pkg.sv
// ----------------------------------------------------------------------------
// hew_pkg
// Shared types and constants for the sliding-window Hurst exponent block.
// ----------------------------------------------------------------------------
package hew_pkg;

   localparam int PRICE_W  = 32;
   localparam int OUT_W    = 32;
   localparam int RET_W    = 32;
   localparam int WIN_W    = 11;
   localparam int SUM_W    = 48;
   localparam int MUL_W    = 34;
   localparam int PROD_W   = 2 * MUL_W;
   localparam int LOG_IN_W = 128;
   localparam int LOG_E_W  = 7;
   localparam int LOG_FRAC = 26;
   localparam int LOG_W    = LOG_E_W + LOG_FRAC;
   localparam int DIV_NW   = 64;
   localparam int DIV_DW   = 34;
   localparam int MEAN_W   = 34;
   localparam int NUM_W    = 36;
   localparam int HV_W     = 35;

   localparam logic [WIN_W-1:0]  WIN_RESET  = 11'd16;
   localparam logic [MUL_W-1:0]  LN2_Q32    = 34'd2977044472;
   localparam logic [PROD_W-1:0] RET_ROUND  = 68'h0_0000_0002_0000_0000;
   localparam logic signed [NUM_W-1:0] TWO_Q24 = 36'sd33554432;
   localparam logic signed [NUM_W-1:0] SAT_MAX = 36'sd2147483647;
   localparam logic signed [NUM_W-1:0] SAT_MIN = -36'sd2147483648;

   typedef struct packed {
      logic [MUL_W-1:0] a;
      logic [MUL_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

   typedef enum logic [1:0] {
      LG_IDLE,
      LG_NORM,
      LG_MUL,
      LG_ACC
   } log_state_type;

   typedef enum logic [1:0] {
      LS_CUR,
      LS_RNG,
      LS_SQR,
      LS_WIN
   } log_sel_type;

   typedef enum logic {
      DS_MEAN,
      DS_HURST
   } div_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOG_GO,
      ST_LOG_WAIT,
      ST_RETURN,
      ST_RET_MUL,
      ST_RET_RND,
      ST_OLD_RD,
      ST_UPDATE,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_PASS,
      ST_RANGE,
      ST_OUT
   } core_state_type;

endpackage

FILE: design/hew_req_if.sv
// ----------------------------------------------------------------------------
// hew_req_if
// Price input channel: valid/ready handshake with one price per beat.
// ----------------------------------------------------------------------------
interface hew_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] price;

   modport source (output valid, output price, input ready);
   modport sink   (input valid, input price, output ready);
endinterface

FILE: design/hew_rsp_if.sv
// ----------------------------------------------------------------------------
// hew_rsp_if
// Result channel: Hurst exponent and fractal dimension per beat.
// ----------------------------------------------------------------------------
interface hew_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] hurst_value;
   logic signed [31:0] fractal_dimension;

   modport source (output valid, output hurst_value, output fractal_dimension, input ready);
   modport sink   (input valid, input hurst_value, input fractal_dimension, output ready);
endinterface

FILE: design/hew_ram.sv
// ----------------------------------------------------------------------------
// hew_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hew_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/hew_mult.sv
// ----------------------------------------------------------------------------
// hew_mult
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module hew_mult import hew_pkg::*; (
   input  logic              clock,
   input  mul_req_type       req,
   output logic [PROD_W-1:0] prod
);

   logic [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(req.a) * PROD_W'(req.b);
   end

   assign prod = prod_ff;

endmodule

FILE: design/hew_log2.sv
// ----------------------------------------------------------------------------
// hew_log2
// Iterative base-2 logarithm with 26 fraction bits: a normalizing shift
// search followed by 26 squaring steps on the shared multiplier.
// ----------------------------------------------------------------------------
module hew_log2 import hew_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [LOG_IN_W-1:0] value,
   input  logic [PROD_W-1:0]   mul_prod,
   output mul_req_type         mul_req,
   output unit_status_type     status,
   output logic [LOG_W-1:0]    result
);

   log_state_type        st_ff, st_in;
   logic [LOG_IN_W-1:0]  v_ff, v_in;
   logic [LOG_E_W-1:0]   e_ff, e_in;
   logic [31:0]          m_ff, m_in;
   logic [LOG_FRAC-1:0]  frac_ff, frac_in;
   logic [4:0]           cnt_ff, cnt_in;
   logic [LOG_W-1:0]     res_ff, res_in;
   logic                 done_ff, done_in;
   logic [32:0]          sq;
   logic [LOG_FRAC-1:0]  frac_next;

   assign sq        = mul_prod[63:31];
   assign frac_next = {frac_ff[LOG_FRAC-2:0], sq[32]};

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= LG_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff    <= v_in;
      e_ff    <= e_in;
      m_ff    <= m_in;
      frac_ff <= frac_in;
      cnt_ff  <= cnt_in;
      res_ff  <= res_in;
   end

   always_comb begin
      st_in   = st_ff;
      v_in    = v_ff;
      e_in    = e_ff;
      m_in    = m_ff;
      frac_in = frac_ff;
      cnt_in  = cnt_ff;
      res_in  = res_ff;
      done_in = 1'b0;
      mul_req = '0;
      unique case (st_ff)
         LG_IDLE: begin
            if (start) begin
               v_in  = value;
               e_in  = LOG_E_W'(LOG_IN_W - 1);
               st_in = LG_NORM;
            end
         end
         LG_NORM: begin
            // Coarse 16-bit steps first, then single bits, until the top bit is set.
            if (v_ff[LOG_IN_W-1 -: 16] == '0) begin
               v_in = v_ff << 16;
               e_in = e_ff - LOG_E_W'(16);
            end else if (!v_ff[LOG_IN_W-1]) begin
               v_in = v_ff << 1;
               e_in = e_ff - LOG_E_W'(1);
            end else begin
               m_in    = v_ff[LOG_IN_W-1 -: 32];
               frac_in = '0;
               cnt_in  = '0;
               st_in   = LG_MUL;
            end
         end
         LG_MUL: begin
            mul_req.a = MUL_W'(m_ff);
            mul_req.b = MUL_W'(m_ff);
            st_in     = LG_ACC;
         end
         LG_ACC: begin
            frac_in = frac_next;
            m_in    = sq[32] ? sq[32:1] : sq[31:0];
            if (cnt_ff == 5'(LOG_FRAC - 1)) begin
               res_in  = {e_ff, frac_next};
               done_in = 1'b1;
               st_in   = LG_IDLE;
            end else begin
               cnt_in = cnt_ff + 5'd1;
               st_in  = LG_MUL;
            end
         end
         default: st_in = LG_IDLE;
      endcase
   end

   assign status.busy = (st_ff != LG_IDLE);
   assign status.done = done_ff;
   assign result      = res_ff;

endmodule

FILE: design/hew_div.sv
// ----------------------------------------------------------------------------
// hew_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hew_div import hew_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_NW-1:0] dividend,
   input  logic [DIV_DW-1:0] divisor,
   output unit_status_type   status,
   output logic [DIV_NW-1:0] quotient
);

   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic [DIV_DW-1:0]   rem_ff, rem_in;
   logic [DIV_DW-1:0]   den_ff, den_in;
   logic [DIV_NW-1:0]   quo_ff, quo_in;
   logic [DIV_DW:0]     rem_sh;
   logic                fits;

   assign rem_sh = {rem_ff, quo_ff[DIV_NW-1]};
   assign fits   = (rem_sh >= {1'b0, den_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (run_ff) begin
         rem_in = fits ? DIV_DW'(rem_sh - {1'b0, den_ff}) : DIV_DW'(rem_sh);
         quo_in = {quo_ff[DIV_NW-2:0], fits};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(DIV_NW - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         den_in = divisor;
         quo_in = dividend;
      end
   end

   assign status.busy = run_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

FILE: design/hurst_exponent_window_core.sv
// Throughput: one price at a time; the logarithm, return scaling and window pass
// share one multiplier, and the mean and exponent divisions share one divider, so
// the sequencer sets the rate.
// Reset: control state is cleared and the window register is set to 16; the
// return RAM is not swept, since a slot is only read after it has been written.
// ----------------------------------------------------------------------------
// hurst_exponent_window_core
// Sliding-window Hurst exponent by rescaled range, fixed point.
// ----------------------------------------------------------------------------
module hurst_exponent_window_core import hew_pkg::*; #(
   parameter int MAX_WINDOW = 1024
) (
   input  logic             clock,
   input  logic             reset,
   hew_req_if.sink          req_bus,
   hew_rsp_if.source        rsp_bus,
   input  logic             csr_wr_en,
   input  logic [WIN_W-1:0] csr_wr_data
);

   localparam int PW = $clog2(MAX_WINDOW + 1);
   localparam int AW = $clog2(MAX_WINDOW);
   localparam int WW = $clog2(MAX_WINDOW + 2);
   localparam int CW = AW + 34;

   function automatic logic signed [OUT_W-1:0] sat32(input logic signed [NUM_W-1:0] v);
      logic signed [OUT_W-1:0] r;
      if (v > SAT_MAX) begin
         r = OUT_W'(SAT_MAX);
      end else if (v < SAT_MIN) begin
         r = OUT_W'(SAT_MIN);
      end else begin
         r = OUT_W'(v);
      end
      return r;
   endfunction

   core_state_type          state_ff, state_in;
   log_sel_type             log_sel_ff, log_sel_in;
   div_sel_type             div_sel_ff, div_sel_in;
   logic [WIN_W-1:0]        window_ff, window_in;
   logic [PRICE_W-1:0]      price_ff, price_in;
   logic                    cur_nz_ff, cur_nz_in;
   logic [LOG_W-1:0]        lcur_ff, lcur_in;
   logic [LOG_W-1:0]        prev_log_ff, prev_log_in;
   logic                    prev_nz_ff, prev_nz_in;
   logic                    dneg_ff, dneg_in;
   logic [31:0]             dmag_ff, dmag_in;
   logic signed [RET_W-1:0] ret_ff, ret_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [WW-1:0]           warm_ff, warm_in;
   logic [AW-1:0]           head_ff, head_in;
   logic signed [MEAN_W-1:0] mean_ff, mean_in;
   logic [AW-1:0]           idx_ff, idx_in;
   logic [PW-1:0]           issue_ff, issue_in;
   logic                    v1_ff, v1_in;
   logic                    v2_ff, v2_in;
   logic                    first_ff, first_in;
   logic signed [CW-1:0]    cum_ff, cum_in;
   logic signed [CW-1:0]    cmax_ff, cmax_in;
   logic signed [CW-1:0]    cmin_ff, cmin_in;
   logic [63:0]             qlo_ff, qlo_in;
   logic [WW-1:0]           qhi_ff, qhi_in;
   logic [LOG_W-1:0]        lr_ff, lr_in;
   logic [LOG_W-1:0]        lq_ff, lq_in;
   logic [LOG_W-1:0]        lp_ff, lp_in;
   logic signed [HV_W-1:0]  h_ff, h_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0] hv_ff, hv_in;
   logic signed [OUT_W-1:0] fd_ff, fd_in;

   logic [PW-1:0]           p_eff;
   logic [AW-1:0]           idx_next;
   logic [CW-1:0]           rng;
   logic [SUM_W-1:0]        sum_mag;
   logic signed [NUM_W-1:0] num_s;
   logic [NUM_W-2:0]        num_mag;
   logic signed [LOG_W:0]   d_s;
   logic signed [34:0]      e_s;
   logic [MUL_W-1:0]        e_mag;
   logic signed [CW-1:0]    cum_n;
   logic signed [RET_W-1:0] old_s;
   logic [64:0]             qlo_sum;
   logic [PROD_W-1:0]       ret_rnd;
   logic [31:0]             ret_q;
   logic [33:0]             quo_lo;

   logic                    log_start;
   logic [LOG_IN_W-1:0]     log_value;
   mul_req_type             log_mul, mul_req;
   unit_status_type         log_stat, div_stat;
   logic [LOG_W-1:0]        log_res;
   logic [PROD_W-1:0]       mul_prod;
   logic                    div_start;
   logic [DIV_NW-1:0]       div_dividend;
   logic [DIV_DW-1:0]       div_divisor;
   logic [DIV_NW-1:0]       div_quo;
   logic                    ram_wr_en;
   logic [AW-1:0]           ram_rd_addr;
   logic [RET_W-1:0]        ram_rd_data;

   // Window length clamped to [2, MAX_WINDOW].
   always_comb begin
      if (window_ff < WIN_W'(2)) begin
         p_eff = PW'(2);
      end else if (32'(window_ff) > 32'(MAX_WINDOW)) begin
         p_eff = PW'(MAX_WINDOW);
      end else begin
         p_eff = PW'(window_ff);
      end
   end

   assign idx_next = (idx_ff == '0) ? AW'(p_eff - PW'(1)) : idx_ff - AW'(1);
   assign rng      = cmax_ff - cmin_ff;
   assign sum_mag  = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign num_s    = $signed({2'b00, lr_ff, 1'b0}) - $signed({3'b000, lq_ff})
                     + $signed({3'b000, lp_ff});
   assign num_mag  = num_s[NUM_W-1] ? (NUM_W-1)'(-num_s) : (NUM_W-1)'(num_s);
   assign d_s      = $signed({1'b0, lcur_ff}) - $signed({1'b0, prev_log_ff});
   assign e_s      = 35'($signed(ram_rd_data)) - 35'(mean_ff);
   assign e_mag    = e_s[34] ? MUL_W'(-e_s) : MUL_W'(e_s);
   assign cum_n    = cum_ff + CW'(e_s);
   assign old_s    = $signed(ram_rd_data);
   assign qlo_sum  = 65'(qlo_ff) + 65'(mul_prod[63:0]);
   assign ret_rnd  = mul_prod + RET_ROUND;
   assign ret_q    = ret_rnd[65:34];
   assign quo_lo   = div_quo[33:0];

   always_comb begin
      unique case (log_sel_ff)
         LS_CUR:  log_value = LOG_IN_W'(price_ff);
         LS_RNG:  log_value = LOG_IN_W'(rng);
         LS_SQR:  log_value = LOG_IN_W'({qhi_ff, qlo_ff});
         LS_WIN:  log_value = LOG_IN_W'(p_eff);
         default: log_value = LOG_IN_W'(p_eff);
      endcase
   end

   always_comb begin
      unique case (div_sel_ff)
         DS_MEAN: begin
            div_dividend = DIV_NW'(sum_mag) + DIV_NW'(p_eff >> 1);
            div_divisor  = DIV_DW'(p_eff);
         end
         DS_HURST: begin
            div_dividend = DIV_NW'({num_mag, 24'd0}) + DIV_NW'(lp_ff);
            div_divisor  = DIV_DW'({lp_ff, 1'b0});
         end
         default: begin
            div_dividend = '0;
            div_divisor  = DIV_DW'(1);
         end
      endcase
   end

   hew_log2 u_log2 (
      .clock    (clock),
      .reset    (reset),
      .start    (log_start),
      .value    (log_value),
      .mul_prod (mul_prod),
      .mul_req  (log_mul),
      .status   (log_stat),
      .result   (log_res)
   );

   hew_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_stat),
      .quotient (div_quo)
   );

   hew_mult u_mult (
      .clock (clock),
      .req   (mul_req),
      .prod  (mul_prod)
   );

   hew_ram #(
      .WIDTH (RET_W),
      .DEPTH (MAX_WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (head_ff),
      .wr_data (ret_ff),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= WIN_RESET;
         prev_nz_ff   <= 1'b0;
         sum_ff       <= '0;
         warm_ff      <= '0;
         head_ff      <= '0;
         issue_ff     <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         prev_nz_ff   <= prev_nz_in;
         sum_ff       <= sum_in;
         warm_ff      <= warm_in;
         head_ff      <= head_in;
         issue_ff     <= issue_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      log_sel_ff  <= log_sel_in;
      div_sel_ff  <= div_sel_in;
      price_ff    <= price_in;
      cur_nz_ff   <= cur_nz_in;
      lcur_ff     <= lcur_in;
      prev_log_ff <= prev_log_in;
      dneg_ff     <= dneg_in;
      dmag_ff     <= dmag_in;
      ret_ff      <= ret_in;
      mean_ff     <= mean_in;
      idx_ff      <= idx_in;
      first_ff    <= first_in;
      cum_ff      <= cum_in;
      cmax_ff     <= cmax_in;
      cmin_ff     <= cmin_in;
      qlo_ff      <= qlo_in;
      qhi_ff      <= qhi_in;
      lr_ff       <= lr_in;
      lq_ff       <= lq_in;
      lp_ff       <= lp_in;
      h_ff        <= h_in;
      hv_ff       <= hv_in;
      fd_ff       <= fd_in;
   end

   always_comb begin
      state_in     = state_ff;
      log_sel_in   = log_sel_ff;
      div_sel_in   = div_sel_ff;
      window_in    = window_ff;
      price_in     = price_ff;
      cur_nz_in    = cur_nz_ff;
      lcur_in      = lcur_ff;
      prev_log_in  = prev_log_ff;
      prev_nz_in   = prev_nz_ff;
      dneg_in      = dneg_ff;
      dmag_in      = dmag_ff;
      ret_in       = ret_ff;
      sum_in       = sum_ff;
      warm_in      = warm_ff;
      head_in      = head_ff;
      mean_in      = mean_ff;
      idx_in       = idx_ff;
      issue_in     = issue_ff;
      v1_in        = 1'b0;
      v2_in        = 1'b0;
      first_in     = first_ff;
      cum_in       = cum_ff;
      cmax_in      = cmax_ff;
      cmin_in      = cmin_ff;
      qlo_in       = qlo_ff;
      qhi_in       = qhi_ff;
      lr_in        = lr_ff;
      lq_in        = lq_ff;
      lp_in        = lp_ff;
      h_in         = h_ff;
      hv_in        = hv_ff;
      fd_in        = fd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      log_start    = 1'b0;
      div_start    = 1'b0;
      ram_wr_en    = 1'b0;
      ram_rd_addr  = head_ff;
      mul_req      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               price_in  = req_bus.price;
               cur_nz_in = (req_bus.price != '0);
               if (req_bus.price != '0) begin
                  log_sel_in = LS_CUR;
                  state_in   = ST_LOG_GO;
               end else begin
                  state_in = ST_RETURN;
               end
            end
         end
         ST_LOG_GO: begin
            log_start = 1'b1;
            state_in  = ST_LOG_WAIT;
         end
         ST_LOG_WAIT: begin
            mul_req = log_mul;
            if (log_stat.done) begin
               unique case (log_sel_ff)
                  LS_CUR: begin
                     lcur_in  = log_res;
                     state_in = ST_RETURN;
                  end
                  LS_RNG: begin
                     lr_in      = log_res;
                     log_sel_in = LS_SQR;
                     state_in   = ST_LOG_GO;
                  end
                  LS_SQR: begin
                     lq_in      = log_res;
                     log_sel_in = LS_WIN;
                     state_in   = ST_LOG_GO;
                  end
                  LS_WIN: begin
                     lp_in      = log_res;
                     div_sel_in = DS_HURST;
                     state_in   = ST_DIV_GO;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_RETURN: begin
            prev_log_in = lcur_ff;
            prev_nz_in  = cur_nz_ff;
            if (warm_ff == '0) begin
               warm_in  = WW'(1);
               state_in = ST_IDLE;
            end else if (cur_nz_ff && prev_nz_ff) begin
               dneg_in  = d_s[LOG_W];
               dmag_in  = d_s[LOG_W] ? 32'(-d_s) : 32'(d_s);
               state_in = ST_RET_MUL;
            end else begin
               ret_in   = '0;
               state_in = ST_OLD_RD;
            end
         end
         ST_RET_MUL: begin
            mul_req.a = MUL_W'(dmag_ff);
            mul_req.b = LN2_Q32;
            state_in  = ST_RET_RND;
         end
         ST_RET_RND: begin
            ret_in   = dneg_ff ? $signed(-ret_q) : $signed(ret_q);
            state_in = ST_OLD_RD;
         end
         ST_OLD_RD: begin
            // The slot about to be overwritten is read for the running sum.
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            ram_wr_en = 1'b1;
            if (warm_ff > WW'(p_eff)) begin
               sum_in = sum_ff - SUM_W'(old_s) + SUM_W'(ret_ff);
            end else begin
               sum_in = sum_ff + SUM_W'(ret_ff);
            end
            head_in = (PW'(head_ff) + PW'(1) >= p_eff) ? '0 : head_ff + AW'(1);
            if (warm_ff <= WW'(p_eff)) begin
               warm_in = warm_ff + WW'(1);
            end
            if (warm_ff >= WW'(p_eff)) begin
               div_sel_in = DS_MEAN;
               state_in   = ST_DIV_GO;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_stat.done) begin
               if (div_sel_ff == DS_MEAN) begin
                  mean_in  = sum_ff[SUM_W-1] ? -$signed(quo_lo) : $signed(quo_lo);
                  idx_in   = head_ff;
                  issue_in = '0;
                  first_in = 1'b1;
                  cum_in   = '0;
                  cmax_in  = '0;
                  cmin_in  = '0;
                  qlo_in   = '0;
                  qhi_in   = '0;
                  state_in = ST_PASS;
               end else begin
                  h_in     = num_s[NUM_W-1] ? -$signed({1'b0, quo_lo})
                                            : $signed({1'b0, quo_lo});
                  state_in = ST_OUT;
               end
            end
         end
         ST_PASS: begin
            // Three-stage walk from newest to oldest: read, deviation and
            // extremes, then square accumulation from the multiplier.
            if (issue_ff < p_eff) begin
               ram_rd_addr = idx_next;
               idx_in      = idx_next;
               issue_in    = issue_ff + PW'(1);
               v1_in       = 1'b1;
            end
            if (v1_ff) begin
               cum_in    = cum_n;
               first_in  = 1'b0;
               if (first_ff || cum_n > cmax_ff) begin
                  cmax_in = cum_n;
               end
               if (first_ff || cum_n < cmin_ff) begin
                  cmin_in = cum_n;
               end
               mul_req.a = e_mag;
               mul_req.b = e_mag;
               v2_in     = 1'b1;
            end
            if (v2_ff) begin
               qlo_in = qlo_sum[63:0];
               qhi_in = qhi_ff + WW'(qlo_sum[64]);
            end
            if (issue_ff == p_eff && !v1_ff && !v2_ff) begin
               state_in = ST_RANGE;
            end
         end
         ST_RANGE: begin
            if (rng == '0) begin
               h_in     = '0;
               state_in = ST_OUT;
            end else begin
               log_sel_in = LS_RNG;
               state_in   = ST_LOG_GO;
            end
         end
         ST_OUT: begin
            // The fractal dimension is taken from the saturated exponent.
            if (!rsp_valid_ff || rsp_bus.ready) begin
               hv_in        = sat32(NUM_W'(h_ff));
               fd_in        = sat32(TWO_Q24 - NUM_W'(sat32(NUM_W'(h_ff))));
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // A window write restarts the history, as at reset.
      if (csr_wr_en) begin
         window_in  = csr_wr_data;
         prev_nz_in = 1'b0;
         sum_in     = '0;
         warm_in    = '0;
         head_in    = '0;
         state_in   = ST_IDLE;
      end
   end

   assign req_bus.ready             = (state_ff == ST_IDLE);
   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.hurst_value       = hv_ff;
   assign rsp_bus.fractal_dimension = fd_ff;

`ifndef SYNTH
   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(log_stat.busy && div_stat.busy))
      else $error("log2 and divider busy together");

   a_head_in_window: assert property (@(posedge clock) disable iff (reset)
      PW'(head_ff) < p_eff)
      else $error("ring head outside window");

   a_warm_bounded: assert property (@(posedge clock) disable iff (reset)
      (WW + 1)'(warm_ff) <= (WW + 1)'(p_eff) + (WW + 1)'(1))
      else $error("warm-up count beyond window plus one");

   a_result_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside output state");
`endif

endmodule
